/* rtl/fcp_pkg.sv */
// ----------------------------------------------------------------------------
// fcp_pkg
// Shared types, constants, rounding and saturation helpers for the camera pose unit.
// ----------------------------------------------------------------------------
`default_nettype none

package fcp_pkg;

    localparam int CFG_DW = 24;
    localparam int CFG_AW = 3;

    // configuration register indexes
    localparam logic [CFG_AW-1:0] REG_MOVE_SPEED  = 3'd0;
    localparam logic [CFG_AW-1:0] REG_WORLD_UP_X  = 3'd1;
    localparam logic [CFG_AW-1:0] REG_WORLD_UP_Y  = 3'd2;
    localparam logic [CFG_AW-1:0] REG_WORLD_UP_Z  = 3'd3;
    localparam logic [CFG_AW-1:0] REG_PITCH_CLAMP = 3'd4;

    // event kinds
    localparam logic [2:0] KIND_LOOK  = 3'd0;
    localparam logic [2:0] KIND_FWD   = 3'd1;
    localparam logic [2:0] KIND_BACK  = 3'd2;
    localparam logic [2:0] KIND_LEFT  = 3'd3;
    localparam logic [2:0] KIND_RIGHT = 3'd4;
    localparam logic [2:0] KIND_UP    = 3'd5;
    localparam logic [2:0] KIND_DOWN  = 3'd6;

    localparam logic [23:0]        SPEED_RESET = 24'd65536;
    localparam logic signed [15:0] ONE_Q14     = 16'sd16384;
    localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;

    localparam int ATAN_LEN = 24;
    localparam logic [31:0] ATAN_TAB [ATAN_LEN] = '{
        32'd188743680, 32'd111421900, 32'd58872272, 32'd29884485,
        32'd15000234,  32'd7507429,   32'd3754631,  32'd1877430,
        32'd938729,    32'd469366,    32'd234683,   32'd117342,
        32'd58671,     32'd29335,     32'd14668,    32'd7334,
        32'd3667,      32'd1833,      32'd917,      32'd458,
        32'd229,       32'd115,       32'd57,       32'd29
    };

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_WRAP,
        ST_COR_YAW_GO,
        ST_COR_YAW_WAIT,
        ST_COR_PIT_GO,
        ST_COR_PIT_WAIT,
        ST_FRONT,
        ST_CROSS,
        ST_SQUARE,
        ST_SQRT_GO,
        ST_SQRT_WAIT,
        ST_DIV_GO,
        ST_DIV_WAIT,
        ST_MOVE,
        ST_VUP,
        ST_FINISH
    } fcp_state_t;

    typedef struct packed {
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
        logic signed [15:0] front_x;
        logic signed [15:0] front_y;
        logic signed [15:0] front_z;
        logic signed [15:0] right_x;
        logic signed [15:0] right_y;
        logic signed [15:0] right_z;
        logic signed [15:0] view_up_x;
        logic signed [15:0] view_up_y;
        logic signed [15:0] view_up_z;
    } pose_t;

    // shift right with rounding to nearest, half away from zero
    function automatic logic signed [67:0] round_shr(input logic signed [67:0] v,
                                                     input int s);
        logic [67:0] m;
        logic        neg;
        neg = v[67];
        m   = neg ? 68'(-v) : 68'(v);
        m   = (m + (68'd1 << (s - 1))) >> s;
        return neg ? -$signed(m) : $signed(m);
    endfunction

    function automatic logic signed [15:0] sat16(input logic signed [67:0] v);
        if (v > 68'sd32767)
            return 16'sh7fff;
        if (v < -68'sd32768)
            return -16'sd32768;
        return v[15:0];
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [67:0] v);
        if (v > 68'sd2147483647)
            return 32'sh7fffffff;
        if (v < -68'sd2147483648)
            return 32'sh80000000;
        return v[31:0];
    endfunction

endpackage

`default_nettype wire

/* rtl/fcp_evt_if.sv */
// ----------------------------------------------------------------------------
// fcp_evt_if
// Input event channel: look or move event with mouse offsets.
// ----------------------------------------------------------------------------
`default_nettype none

interface fcp_evt_if;
    logic               valid;
    logic               ready;
    logic [2:0]         kind;
    logic signed [15:0] mouse_dx;
    logic signed [15:0] mouse_dy;

    modport source (output valid, output kind, output mouse_dx, output mouse_dy,
                    input ready);
    modport sink   (input valid, input kind, input mouse_dx, input mouse_dy,
                    output ready);
endinterface

`default_nettype wire

/* rtl/fcp_pose_if.sv */
// ----------------------------------------------------------------------------
// fcp_pose_if
// Result channel: position and the three view-matrix rows.
// ----------------------------------------------------------------------------
`default_nettype none

interface fcp_pose_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic signed [15:0] front_x;
    logic signed [15:0] front_y;
    logic signed [15:0] front_z;
    logic signed [15:0] right_x;
    logic signed [15:0] right_y;
    logic signed [15:0] right_z;
    logic signed [15:0] view_up_x;
    logic signed [15:0] view_up_y;
    logic signed [15:0] view_up_z;

    modport source (output valid, output pos_x, output pos_y, output pos_z,
                    output front_x, output front_y, output front_z,
                    output right_x, output right_y, output right_z,
                    output view_up_x, output view_up_y, output view_up_z,
                    input ready);
    modport sink   (input valid, input pos_x, input pos_y, input pos_z,
                    input front_x, input front_y, input front_z,
                    input right_x, input right_y, input right_z,
                    input view_up_x, input view_up_y, input view_up_z,
                    output ready);
endinterface

`default_nettype wire

/* rtl/fcp_cordic.sv */
// ----------------------------------------------------------------------------
// fcp_cordic
// Iterative rotation-mode CORDIC: sine and cosine in Q1.30 of an angle
// given in tenths of a degree, one micro-rotation per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module fcp_cordic
    import fcp_pkg::*;
#(
    parameter int STEPS = 16
)
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    input  wire logic [11:0]        angle,
    output logic                    done,
    output logic signed [33:0]      sin_q30,
    output logic signed [33:0]      cos_q30
);

    localparam int IW = $clog2(STEPS);

    logic                busy_reg;
    logic                done_reg;
    logic [IW-1:0]       i_reg;
    logic signed [33:0]  x_reg;
    logic signed [33:0]  y_reg;
    logic signed [31:0]  z_reg;
    logic                neg_reg;
    logic signed [33:0]  sin_reg;
    logic signed [33:0]  cos_reg;

    // angle folding into -90..90 degrees
    logic signed [12:0]  a_fold;
    logic                a_neg;
    logic [9:0]          a_mag;
    logic [28:0]         z_int;
    logic [24:0]         z_frac;
    logic signed [31:0]  z_start;

    logic signed [33:0]  dx;
    logic signed [33:0]  dy;
    logic signed [31:0]  at;
    logic signed [33:0]  x_next;
    logic signed [33:0]  y_next;
    logic signed [31:0]  z_next;

    always_comb
    begin
        a_fold = $signed({1'b0, angle});
        a_neg  = 1'b0;
        if (a_fold > 13'sd900 && a_fold < 13'sd2700)
        begin
            a_fold = a_fold - 13'sd1800;
            a_neg  = 1'b1;
        end
        else if (a_fold >= 13'sd2700)
        begin
            a_fold = a_fold - 13'sd3600;
        end
        a_mag   = a_fold[12] ? 10'(-a_fold) : 10'(a_fold);
        // tenths to 2^-22 degree: m*419430 + floor((4m+5)/10)
        z_int   = 29'(a_mag) * 29'd419430;
        z_frac  = (25'({a_mag, 2'b00} + 12'd5) * 25'd6554) >> 16;
        z_start = $signed(32'(z_int) + 32'(z_frac));
        if (a_fold[12])
            z_start = -z_start;
    end

    always_comb
    begin
        dx = y_reg >>> i_reg;
        dy = x_reg >>> i_reg;
        at = $signed(ATAN_TAB[5'(i_reg)]);
        if (!z_reg[31])
        begin
            x_next = x_reg - dx;
            y_next = y_reg + dy;
            z_next = z_reg - at;
        end
        else
        begin
            x_next = x_reg + dx;
            y_next = y_reg - dy;
            z_next = z_reg + at;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            i_reg    <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                i_reg    <= '0;
            end
            else if (busy_reg)
            begin
                i_reg <= i_reg + 1'b1;
                if (i_reg == IW'(STEPS - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            x_reg   <= CORDIC_GAIN;
            y_reg   <= '0;
            z_reg   <= z_start;
            neg_reg <= a_neg;
        end
        else if (busy_reg)
        begin
            x_reg <= x_next;
            y_reg <= y_next;
            z_reg <= z_next;
            if (i_reg == IW'(STEPS - 1))
            begin
                sin_reg <= neg_reg ? -y_next : y_next;
                cos_reg <= neg_reg ? -x_next : x_next;
            end
        end
    end

    assign done    = done_reg;
    assign sin_q30 = sin_reg;
    assign cos_q30 = cos_reg;

endmodule

`default_nettype wire

/* rtl/fcp_sqrt.sv */
// ----------------------------------------------------------------------------
// fcp_sqrt
// Bit-serial integer square root of a 64-bit value, one result bit a cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module fcp_sqrt
    import fcp_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    input  wire logic [63:0] radicand,
    output logic             done,
    output logic [31:0]      root
);

    logic        busy_reg;
    logic        done_reg;
    logic [4:0]  cnt_reg;
    logic [63:0] v_reg;
    logic [63:0] res_reg;
    logic [63:0] bit_reg;
    logic [64:0] trial;
    logic        fits;

    assign trial = {1'b0, res_reg} + {1'b0, bit_reg};
    assign fits  = {1'b0, v_reg} >= trial;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == 5'd31)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            v_reg   <= radicand;
            res_reg <= '0;
            bit_reg <= 64'd1 << 62;
        end
        else if (busy_reg)
        begin
            if (fits)
            begin
                v_reg   <= v_reg - trial[63:0];
                res_reg <= (res_reg >> 1) + bit_reg;
            end
            else
            begin
                res_reg <= res_reg >> 1;
            end
            bit_reg <= bit_reg >> 2;
        end
    end

    assign done = done_reg;
    assign root = res_reg[31:0];

endmodule

`default_nettype wire

/* rtl/fcp_div.sv */
// ----------------------------------------------------------------------------
// fcp_div
// Restoring divider for the right-vector normalise; the quotient is known
// to stay below 2^15, so only fifteen quotient bits are produced.
// ----------------------------------------------------------------------------
`default_nettype none

module fcp_div
    import fcp_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    input  wire logic [46:0] num,
    input  wire logic [31:0] den,
    output logic             done,
    output logic [14:0]      quo
);

    logic        busy_reg;
    logic        done_reg;
    logic [3:0]  cnt_reg;
    logic [32:0] rem_reg;
    logic [14:0] low_reg;
    logic [31:0] den_reg;
    logic [32:0] shifted;
    logic        take;

    assign shifted = {rem_reg[31:0], low_reg[14]};
    assign take    = shifted >= {1'b0, den_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == 4'd14)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // quotient bits shift in where the numerator bits shift out
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= {1'b0, num[46:15]};
            low_reg <= num[14:0];
            den_reg <= den;
        end
        else if (busy_reg)
        begin
            rem_reg <= take ? (shifted - {1'b0, den_reg}) : shifted;
            low_reg <= {low_reg[13:0], take};
        end
    end

    assign done = done_reg;
    assign quo  = low_reg;

endmodule

`default_nettype wire

/* rtl/fps_camera_pose_update.sv */
// ----------------------------------------------------------------------------
// fps_camera_pose_update
// First-person camera pose unit: look events turn yaw and pitch and rebuild
// the front vector, move events step the position; every event returns one
// pose with position, front, right and view up rows.
// ----------------------------------------------------------------------------
// usage
//   evt  : valid/ready channel, one transaction per look or move event
//   pose : valid/ready channel, exactly one transaction per event
//   cfg  : cfg_we/cfg_index/cfg_data, write only, while the unit is idle
// timing
//   evt.ready is high only in the idle state; an event then runs alone
//   through one shared 34x34 multiplier, a CORDIC unit, a bit-serial square
//   root and a restoring divider. a look event makes two CORDIC passes,
//   yaw then pitch, after a wrap loop that brings yaw and pitch back into
//   range; a move event skips both. a degenerate right vector skips the
//   divisions. the square root and the three divisions take the largest
//   share of an event's time
// stalls
//   the result sits in an output register; the next event is accepted while
//   it waits, and that event holds in its last state until the pose is taken
// reset
//   yaw, pitch and position zero, front (1,0,0), config at its reset values
// ----------------------------------------------------------------------------
`default_nettype none

module fps_camera_pose_update
    import fcp_pkg::*;
#(
    parameter int CORDIC_STEPS = 16
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    fcp_evt_if.sink                evt,
    fcp_pose_if.source             pose,
    input  wire logic              cfg_we,
    input  wire logic [CFG_AW-1:0] cfg_index,
    input  wire logic [CFG_DW-1:0] cfg_data
);

    // configuration
    logic [23:0]         speed_reg;
    logic signed [15:0]  up_reg [3];
    logic                clamp_reg;

    // pose state
    logic [11:0]         yaw_reg;
    logic signed [11:0]  pitch_reg;
    logic signed [31:0]  pos_reg [3];
    logic signed [15:0]  front_reg [3];

    // sequencer
    fcp_state_t          state_reg, state_next;
    logic [1:0]          k_reg, k_next;
    logic                term_reg, term_next;
    logic                phase_reg, phase_next;

    // working registers
    logic [2:0]          kind_reg;
    logic signed [16:0]  yaw_w_reg;
    logic signed [16:0]  pq_reg;
    logic signed [33:0]  sy_reg, cy_reg, sp_reg, cp_reg;
    logic signed [67:0]  prod_reg;
    logic signed [33:0]  acc_reg;
    logic signed [33:0]  c_reg [3];
    logic [63:0]         sum_reg;
    logic [31:0]         len_reg;
    logic signed [15:0]  right_reg [3];
    logic signed [15:0]  vup_reg [3];
    pose_t               pose_reg;
    logic                pose_valid_reg;

    // shared multiplier
    logic signed [33:0]  mul_a, mul_b;
    logic signed [67:0]  prod;

    // sub-unit handshakes
    logic                cor_start, cor_done;
    logic [11:0]         cor_angle;
    logic signed [33:0]  cor_sin, cor_cos;
    logic                sqrt_start, sqrt_done;
    logic [31:0]         sqrt_root;
    logic                div_start, div_done;
    logic [46:0]         div_num;
    logic [14:0]         div_quo;

    // helpers
    logic                accept;
    logic                mul_kind;
    logic                move_neg;
    logic                mac_state, last_term, last_k;
    logic                yaw_ok, pq_ok;
    logic signed [16:0]  p_raw, p_clamped;
    logic signed [12:0]  pitch_ext;
    logic [11:0]         pitch_angle;
    logic signed [33:0]  prod34;
    logic signed [33:0]  diff34;
    logic signed [15:0]  front_val;
    logic signed [15:0]  vup_val;
    logic signed [31:0]  move_val;
    logic signed [33:0]  c_sel;
    logic [31:0]         c_abs;
    logic                fin_go;

    assign accept    = evt.valid && evt.ready;
    assign evt.ready = (state_reg == ST_IDLE);
    assign mul_kind  = kind_reg inside {KIND_FWD, KIND_BACK, KIND_LEFT, KIND_RIGHT};
    assign move_neg  = kind_reg inside {KIND_BACK, KIND_LEFT};
    assign fin_go    = !pose_valid_reg || pose.ready;

    assign p_raw     = $signed({{5{pitch_reg[11]}}, pitch_reg})
                     - $signed({evt.mouse_dy[15], evt.mouse_dy});
    assign p_clamped = (p_raw > 17'sd890)  ? 17'sd890 :
                       (p_raw < -17'sd890) ? -17'sd890 : p_raw;
    assign yaw_ok    = !yaw_w_reg[16] && (yaw_w_reg < 17'sd3600);
    assign pq_ok     = !pq_reg[16] && (pq_reg < 17'sd3600);
    assign pitch_ext = $signed({pitch_reg[11], pitch_reg});
    assign pitch_angle = pitch_reg[11] ? 12'(pitch_ext + 13'sd3600) : 12'(pitch_ext);

    assign prod34    = $signed(prod_reg[33:0]);
    assign diff34    = acc_reg - prod34;
    assign front_val = sat16(round_shr(round_shr(prod_reg, 30), 16));
    assign vup_val   = sat16(round_shr(68'(diff34), 14));
    assign move_val  = move_neg ? sat32(68'(pos_reg[k_reg]) - round_shr(prod_reg, 14))
                                : sat32(68'(pos_reg[k_reg]) + round_shr(prod_reg, 14));
    assign c_sel     = c_reg[k_reg];
    assign c_abs     = c_sel[33] ? 32'(-c_sel) : 32'(c_sel);
    assign div_num   = 47'({c_abs, 14'd0}) + 47'(len_reg[31:1]);

    // operand selection for the shared multiplier
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            ST_FRONT:
            begin
                mul_a = (k_reg == 2'd0) ? cy_reg : sy_reg;
                mul_b = cp_reg;
            end
            ST_CROSS:
            begin
                case (k_reg)
                    2'd0:
                    begin
                        mul_a = 34'(term_reg ? front_reg[2] : front_reg[1]);
                        mul_b = 34'(term_reg ? up_reg[1] : up_reg[2]);
                    end
                    2'd1:
                    begin
                        mul_a = 34'(term_reg ? front_reg[0] : front_reg[2]);
                        mul_b = 34'(term_reg ? up_reg[2] : up_reg[0]);
                    end
                    default:
                    begin
                        mul_a = 34'(term_reg ? front_reg[1] : front_reg[0]);
                        mul_b = 34'(term_reg ? up_reg[0] : up_reg[1]);
                    end
                endcase
            end
            ST_SQUARE:
            begin
                mul_a = c_sel;
                mul_b = c_sel;
            end
            ST_MOVE:
            begin
                mul_a = 34'((kind_reg inside {KIND_FWD, KIND_BACK}) ? front_reg[k_reg]
                                                                     : right_reg[k_reg]);
                mul_b = $signed({10'd0, speed_reg});
            end
            ST_VUP:
            begin
                case (k_reg)
                    2'd0:
                    begin
                        mul_a = 34'(term_reg ? right_reg[2] : right_reg[1]);
                        mul_b = 34'(term_reg ? front_reg[1] : front_reg[2]);
                    end
                    2'd1:
                    begin
                        mul_a = 34'(term_reg ? right_reg[0] : right_reg[2]);
                        mul_b = 34'(term_reg ? front_reg[2] : front_reg[0]);
                    end
                    default:
                    begin
                        mul_a = 34'(term_reg ? right_reg[1] : right_reg[0]);
                        mul_b = 34'(term_reg ? front_reg[0] : front_reg[1]);
                    end
                endcase
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign prod = mul_a * mul_b;

    assign mac_state = (state_reg == ST_FRONT) || (state_reg == ST_CROSS)
                    || (state_reg == ST_SQUARE) || (state_reg == ST_MOVE)
                    || (state_reg == ST_VUP);
    assign last_term = !((state_reg == ST_CROSS) || (state_reg == ST_VUP)) || term_reg;
    assign last_k    = (state_reg == ST_FRONT) ? (k_reg == 2'd1) : (k_reg == 2'd2);

    // sequencer: each product takes a multiply phase and a consume phase
    always_comb
    begin
        state_next = state_reg;
        k_next     = k_reg;
        term_next  = term_reg;
        phase_next = phase_reg;
        cor_start  = 1'b0;
        cor_angle  = yaw_reg;
        sqrt_start = 1'b0;
        div_start  = 1'b0;

        if (mac_state && phase_reg)
        begin
            phase_next = 1'b0;
            term_next  = !last_term;
            if (last_term)
                k_next = last_k ? 2'd0 : k_reg + 2'd1;
        end
        else if (mac_state)
        begin
            phase_next = 1'b1;
        end

        case (state_reg)
            ST_IDLE:
            begin
                k_next     = 2'd0;
                term_next  = 1'b0;
                phase_next = 1'b0;
                if (accept)
                    state_next = (evt.kind == KIND_LOOK) ? ST_WRAP : ST_CROSS;
            end
            ST_WRAP:
            begin
                if (yaw_ok && pq_ok)
                    state_next = ST_COR_YAW_GO;
            end
            ST_COR_YAW_GO:
            begin
                cor_start  = 1'b1;
                state_next = ST_COR_YAW_WAIT;
            end
            ST_COR_YAW_WAIT:
            begin
                if (cor_done)
                    state_next = ST_COR_PIT_GO;
            end
            ST_COR_PIT_GO:
            begin
                cor_start  = 1'b1;
                cor_angle  = pitch_angle;
                state_next = ST_COR_PIT_WAIT;
            end
            ST_COR_PIT_WAIT:
            begin
                if (cor_done)
                    state_next = ST_FRONT;
            end
            ST_FRONT:
            begin
                if (phase_reg && last_k)
                    state_next = ST_CROSS;
            end
            ST_CROSS:
            begin
                if (phase_reg && last_term && last_k)
                    state_next = ST_SQUARE;
            end
            ST_SQUARE:
            begin
                if (phase_reg && last_k)
                    state_next = ST_SQRT_GO;
            end
            ST_SQRT_GO:
            begin
                sqrt_start = 1'b1;
                state_next = ST_SQRT_WAIT;
            end
            ST_SQRT_WAIT:
            begin
                if (sqrt_done)
                    state_next = ST_DIV_GO;
            end
            ST_DIV_GO:
            begin
                // zero cross product: right is set to zero, no division
                if (len_reg == 32'd0)
                begin
                    k_next     = 2'd0;
                    state_next = ST_MOVE;
                end
                else
                begin
                    div_start  = 1'b1;
                    state_next = ST_DIV_WAIT;
                end
            end
            ST_DIV_WAIT:
            begin
                if (div_done)
                begin
                    k_next     = (k_reg == 2'd2) ? 2'd0 : k_reg + 2'd1;
                    state_next = (k_reg == 2'd2) ? ST_MOVE : ST_DIV_GO;
                end
            end
            ST_MOVE:
            begin
                if (!mul_kind)
                begin
                    k_next     = 2'd0;
                    phase_next = 1'b0;
                    state_next = ST_VUP;
                end
                else if (phase_reg && last_k)
                begin
                    state_next = ST_VUP;
                end
            end
            ST_VUP:
            begin
                if (phase_reg && last_term && last_k)
                    state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                if (fin_go)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control, configuration and pose state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            k_reg          <= '0;
            term_reg       <= 1'b0;
            phase_reg      <= 1'b0;
            speed_reg      <= SPEED_RESET;
            up_reg[0]      <= '0;
            up_reg[1]      <= ONE_Q14;
            up_reg[2]      <= '0;
            clamp_reg      <= 1'b1;
            yaw_reg        <= '0;
            pitch_reg      <= '0;
            pos_reg[0]     <= '0;
            pos_reg[1]     <= '0;
            pos_reg[2]     <= '0;
            front_reg[0]   <= ONE_Q14;
            front_reg[1]   <= '0;
            front_reg[2]   <= '0;
            pose_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            k_reg     <= k_next;
            term_reg  <= term_next;
            phase_reg <= phase_next;

            if (cfg_we)
            begin
                case (cfg_index)
                    REG_MOVE_SPEED:  speed_reg <= cfg_data[23:0];
                    REG_WORLD_UP_X:  up_reg[0] <= $signed(cfg_data[15:0]);
                    REG_WORLD_UP_Y:  up_reg[1] <= $signed(cfg_data[15:0]);
                    REG_WORLD_UP_Z:  up_reg[2] <= $signed(cfg_data[15:0]);
                    REG_PITCH_CLAMP: clamp_reg <= cfg_data[0];
                    default: ;
                endcase
            end

            if (state_reg == ST_FINISH && fin_go)
                pose_valid_reg <= 1'b1;
            else if (pose.valid && pose.ready)
                pose_valid_reg <= 1'b0;

            case (state_reg)
                ST_WRAP:
                begin
                    if (yaw_ok && pq_ok)
                    begin
                        yaw_reg   <= yaw_w_reg[11:0];
                        pitch_reg <= 12'(pq_reg - 17'sd1800);
                    end
                end
                ST_FRONT:
                begin
                    if (phase_reg)
                    begin
                        if (k_reg == 2'd0)
                        begin
                            front_reg[0] <= front_val;
                        end
                        else
                        begin
                            front_reg[2] <= front_val;
                            front_reg[1] <= sat16(round_shr(68'(sp_reg), 16));
                        end
                    end
                end
                ST_MOVE:
                begin
                    if (mul_kind)
                    begin
                        if (phase_reg)
                            pos_reg[k_reg] <= move_val;
                    end
                    else if (kind_reg == KIND_UP)
                    begin
                        pos_reg[1] <= sat32(68'(pos_reg[1]) - $signed({44'd0, speed_reg}));
                    end
                    else if (kind_reg == KIND_DOWN)
                    begin
                        pos_reg[1] <= sat32(68'(pos_reg[1]) + $signed({44'd0, speed_reg}));
                    end
                end
                default: ;
            endcase
        end
    end

    // working datapath registers
    always_ff @(posedge clk)
    begin
        prod_reg <= prod;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    kind_reg  <= evt.kind;
                    yaw_w_reg <= $signed({5'd0, yaw_reg})
                               - $signed({evt.mouse_dx[15], evt.mouse_dx});
                    pq_reg    <= (clamp_reg ? p_clamped : p_raw) + 17'sd1800;
                end
            end
            ST_WRAP:
            begin
                if (yaw_w_reg[16])
                    yaw_w_reg <= yaw_w_reg + 17'sd3600;
                else if (!yaw_ok)
                    yaw_w_reg <= yaw_w_reg - 17'sd3600;
                if (pq_reg[16])
                    pq_reg <= pq_reg + 17'sd3600;
                else if (!pq_ok)
                    pq_reg <= pq_reg - 17'sd3600;
            end
            ST_COR_YAW_WAIT:
            begin
                if (cor_done)
                begin
                    sy_reg <= cor_sin;
                    cy_reg <= cor_cos;
                end
            end
            ST_COR_PIT_WAIT:
            begin
                if (cor_done)
                begin
                    sp_reg <= cor_sin;
                    cp_reg <= cor_cos;
                end
            end
            ST_CROSS:
            begin
                if (phase_reg)
                begin
                    if (!term_reg)
                        acc_reg <= prod34;
                    else
                        c_reg[k_reg] <= diff34;
                end
            end
            ST_SQUARE:
            begin
                if (phase_reg)
                    sum_reg <= (k_reg == 2'd0) ? prod_reg[63:0] : sum_reg + prod_reg[63:0];
            end
            ST_SQRT_WAIT:
            begin
                if (sqrt_done)
                    len_reg <= sqrt_root;
            end
            ST_DIV_GO:
            begin
                if (len_reg == 32'd0)
                begin
                    right_reg[0] <= '0;
                    right_reg[1] <= '0;
                    right_reg[2] <= '0;
                end
            end
            ST_DIV_WAIT:
            begin
                if (div_done)
                    right_reg[k_reg] <= c_sel[33] ? -$signed({1'b0, div_quo})
                                                  : $signed({1'b0, div_quo});
            end
            ST_VUP:
            begin
                if (phase_reg)
                begin
                    if (!term_reg)
                        acc_reg <= prod34;
                    else
                        vup_reg[k_reg] <= vup_val;
                end
            end
            ST_FINISH:
            begin
                if (fin_go)
                begin
                    pose_reg.pos_x     <= pos_reg[0];
                    pose_reg.pos_y     <= pos_reg[1];
                    pose_reg.pos_z     <= pos_reg[2];
                    pose_reg.front_x   <= front_reg[0];
                    pose_reg.front_y   <= front_reg[1];
                    pose_reg.front_z   <= front_reg[2];
                    pose_reg.right_x   <= right_reg[0];
                    pose_reg.right_y   <= right_reg[1];
                    pose_reg.right_z   <= right_reg[2];
                    pose_reg.view_up_x <= vup_reg[0];
                    pose_reg.view_up_y <= vup_reg[1];
                    pose_reg.view_up_z <= vup_reg[2];
                end
            end
            default: ;
        endcase
    end

    fcp_cordic #(
        .STEPS (CORDIC_STEPS)
    ) u_cordic (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (cor_start),
        .angle   (cor_angle),
        .done    (cor_done),
        .sin_q30 (cor_sin),
        .cos_q30 (cor_cos)
    );

    fcp_sqrt u_sqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (sqrt_start),
        .radicand (sum_reg),
        .done     (sqrt_done),
        .root     (sqrt_root)
    );

    fcp_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (len_reg),
        .done  (div_done),
        .quo   (div_quo)
    );

    assign pose.valid     = pose_valid_reg;
    assign pose.pos_x     = pose_reg.pos_x;
    assign pose.pos_y     = pose_reg.pos_y;
    assign pose.pos_z     = pose_reg.pos_z;
    assign pose.front_x   = pose_reg.front_x;
    assign pose.front_y   = pose_reg.front_y;
    assign pose.front_z   = pose_reg.front_z;
    assign pose.right_x   = pose_reg.right_x;
    assign pose.right_y   = pose_reg.right_y;
    assign pose.right_z   = pose_reg.right_z;
    assign pose.view_up_x = pose_reg.view_up_x;
    assign pose.view_up_y = pose_reg.view_up_y;
    assign pose.view_up_z = pose_reg.view_up_z;

    // the CORDIC unit and the divider only finish while the sequencer waits for them
    a_cordic_done_waited: assert property (@(posedge clk) disable iff (!rst_n)
        cor_done |-> (state_reg == ST_COR_YAW_WAIT || state_reg == ST_COR_PIT_WAIT))
        else $error("cordic finished outside a wait state");

    a_div_done_waited: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> (state_reg == ST_DIV_WAIT))
        else $error("divider finished outside its wait state");

    a_yaw_range: assert property (@(posedge clk) disable iff (!rst_n)
        yaw_reg <= 12'd3599)
        else $error("yaw left its wrap range");

    a_pitch_range: assert property (@(posedge clk) disable iff (!rst_n)
        (pitch_reg >= -12'sd1800) && (pitch_reg <= 12'sd1799))
        else $error("pitch left its wrap range");

    a_pose_from_finish: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(pose_valid_reg) |-> $past(state_reg == ST_FINISH))
        else $error("result published outside the finish state");

endmodule

`default_nettype wire
